// ===== hdl/erc_pkg.sv =====
// shared types and constants for the ellipsoid region contact pipeline
package erc_pkg;

  localparam int COORD_W = 32;
  // saturation width of the per-axis normalized ratio
  localparam int Q_W = 32;

  typedef enum logic [2:0] {
    CFG_CENTRE_X  = 3'd0,
    CFG_CENTRE_Y  = 3'd1,
    CFG_CENTRE_Z  = 3'd2,
    CFG_SEMI_A    = 3'd3,
    CFG_SEMI_B    = 3'd4,
    CFG_SEMI_C    = 3'd5,
    CFG_CUTOFF    = 3'd6,
    CFG_INTERIOR  = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
  } erc_in_t;

  typedef struct packed {
    logic                      is_inside;
    logic                      has_contact;
    logic [COORD_W-2:0]        gap;
    logic signed [COORD_W-1:0] push_x;
    logic signed [COORD_W-1:0] push_y;
    logic signed [COORD_W-1:0] push_z;
  } erc_out_t;

endpackage

// ===== hdl/ellipsoid_region_contact.sv =====
// top level: point-in-ellipsoid test with surface gap and contact vector
// One word is taken in every cycle and each word gives one result word. NQ is
// the per-axis ratio divider depth (one quotient bit per stage), H2 the square
// root depth of the normalized radius and N2 the depth of the radius and
// contact vector dividers. busy_o stays low, and done_o strobes for one cycle
// with result_o; the receiver must take it then, there is no back pressure.
// Configuration writes are always ready and must only be issued while no word
// is in flight.
module ellipsoid_region_contact
  import erc_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  erc_in_t            in_i,
  output logic               done_o,
  output erc_out_t           result_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_idx_i,
  input  logic [COORD_W-1:0] cfg_data_i
);

  localparam int M_W    = COORD_W + 1;
  localparam int SEMI_W = COORD_W - 1;
  localparam int NQ     = M_W + FRAC_BITS;
  localparam int QX_W   = (NQ > Q_W) ? NQ : Q_W;
  localparam int QSQ_W  = 2 * Q_W - FRAC_BITS;
  localparam int RSQ_W  = QSQ_W + 2;
  localparam int SQ2_N  = ((RSQ_W + FRAC_BITS + 1) / 2) * 2;
  localparam int H2     = SQ2_N / 2;
  localparam int SSQ_W  = 2 * M_W + 2;
  localparam int R_W    = SSQ_W / 2;
  localparam int N2     = R_W + FRAC_BITS;
  localparam int T_RSQ  = NQ + 5;
  localparam int T_RS   = T_RSQ + H2;
  localparam int DR     = T_RS - 4 - R_W;
  localparam int DM     = T_RS - 2;
  localparam int DC     = H2;
  localparam int LAT    = T_RS + N2 + 2;

  localparam logic [RSQ_W-1:0]  ONE_Q    = RSQ_W'(1) << FRAC_BITS;
  localparam logic [QX_W-1:0]   Q_CAP    = QX_W'({Q_W{1'b1}});
  localparam logic [N2-1:0]     GAP_MAX  = N2'({(COORD_W-1){1'b1}});
  localparam logic signed [N2:0] PUSH_MAX =
      $signed(((N2+1)'(1) << (COORD_W-1)) - (N2+1)'(1));
  localparam logic signed [N2:0] PUSH_MIN = -PUSH_MAX - (N2+1)'(1);

  // configuration registers
  logic signed [2:0][COORD_W-1:0] centre_q;
  logic [2:0][SEMI_W-1:0]         semi_q;
  logic [SEMI_W-1:0]              cutoff_q;
  logic                           interior_q;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      centre_q   <= '0;
      semi_q[0]  <= SEMI_W'(1) << FRAC_BITS;
      semi_q[1]  <= SEMI_W'(1) << FRAC_BITS;
      semi_q[2]  <= SEMI_W'(1) << FRAC_BITS;
      cutoff_q   <= '0;
      interior_q <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_CENTRE_X: centre_q[0] <= cfg_data_i;
        CFG_CENTRE_Y: centre_q[1] <= cfg_data_i;
        CFG_CENTRE_Z: centre_q[2] <= cfg_data_i;
        CFG_SEMI_A:   semi_q[0]   <= cfg_data_i[SEMI_W-1:0];
        CFG_SEMI_B:   semi_q[1]   <= cfg_data_i[SEMI_W-1:0];
        CFG_SEMI_C:   semi_q[2]   <= cfg_data_i[SEMI_W-1:0];
        CFG_CUTOFF:   cutoff_q    <= cfg_data_i[SEMI_W-1:0];
        CFG_INTERIOR: interior_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic accept;
  assign accept = start_i && !busy_o;

  erc_delay #(.W(1), .DEPTH(LAT)) u_dly_vld (
    .clk_i, .rst_ni, .d_i(accept), .q_o(done_o)
  );

  logic signed [2:0][COORD_W-1:0] pos;
  assign pos[0] = in_i.pos_x;
  assign pos[1] = in_i.pos_y;
  assign pos[2] = in_i.pos_z;

  logic signed [2:0][M_W-1:0] d_q;
  logic [2:0][M_W-1:0]        m_q;
  logic [2:0]                 neg_q;
  logic [2:0][2*M_W-1:0]      msq_q;
  logic [SSQ_W-1:0]           ssq_q;
  logic [2:0][NQ-1:0]         quot;
  logic [2:0][Q_W-1:0]        qsat_q;
  logic [2:0][QSQ_W-1:0]      qsq_q;
  logic [RSQ_W-1:0]           rsq_q;
  logic [R_W-1:0]             r_root;
  logic [R_W-1:0]             r_dly;
  logic [H2-1:0]              rs;
  logic [2:0][M_W-1:0]        m_dly;
  logic [2:0]                 neg_dly;
  logic                       inside_rsq;
  logic                       cand_rsq;
  logic                       inside_dly;
  logic                       cand_dly;
  logic [N2-1:0]              radius;
  logic [2:0][N2-1:0]         pdiv;

  for (genvar a = 0; a < 3; a++) begin : g_axis
    logic [SEMI_W-1:0] semi_eff;
    logic [QX_W-1:0]   quot_x;
    logic [2*Q_W-1:0]  qprod;

    assign semi_eff = (semi_q[a] == '0) ? SEMI_W'(1) : semi_q[a];
    assign quot_x   = QX_W'(quot[a]);
    assign qprod    = qsat_q[a] * qsat_q[a];

    always_ff @(posedge clk_i) begin
      d_q[a]    <= $signed({pos[a][COORD_W-1], pos[a]})
                 - $signed({centre_q[a][COORD_W-1], centre_q[a]});
      neg_q[a]  <= d_q[a][M_W-1];
      m_q[a]    <= d_q[a][M_W-1] ? M_W'(-d_q[a]) : M_W'(d_q[a]);
      msq_q[a]  <= m_q[a] * m_q[a];
      qsat_q[a] <= (quot_x > Q_CAP) ? Q_CAP[Q_W-1:0] : quot_x[Q_W-1:0];
      qsq_q[a]  <= qprod[2*Q_W-1:FRAC_BITS];
    end

    erc_div #(.N(NQ), .D(SEMI_W)) u_div_q (
      .clk_i,
      .num_i ({m_q[a], {FRAC_BITS{1'b0}}}),
      .den_i (semi_eff),
      .quot_o(quot[a])
    );

    erc_div #(.N(N2), .D(H2)) u_div_push (
      .clk_i,
      .num_i (N2'({m_dly[a], {FRAC_BITS{1'b0}}})),
      .den_i (rs),
      .quot_o(pdiv[a])
    );
  end

  always_ff @(posedge clk_i) begin
    ssq_q <= SSQ_W'(msq_q[0]) + SSQ_W'(msq_q[1]) + SSQ_W'(msq_q[2]);
    rsq_q <= RSQ_W'(qsq_q[0]) + RSQ_W'(qsq_q[1]) + RSQ_W'(qsq_q[2]);
  end

  // interior contact needs a nonzero normalized radius
  always_comb begin
    inside_rsq = rsq_q <= ONE_Q;
    cand_rsq   = interior_q ? (rsq_q != '0) && inside_rsq : rsq_q >= ONE_Q;
  end

  erc_sqrt #(.N(SSQ_W)) u_sqrt_r (
    .clk_i, .rad_i(ssq_q), .root_o(r_root)
  );

  erc_sqrt #(.N(SQ2_N)) u_sqrt_rs (
    .clk_i, .rad_i(SQ2_N'({rsq_q, {FRAC_BITS{1'b0}}})), .root_o(rs)
  );

  erc_delay #(.W(R_W), .DEPTH(DR)) u_dly_r (
    .clk_i, .rst_ni, .d_i(r_root), .q_o(r_dly)
  );

  erc_delay #(.W(3*M_W+3), .DEPTH(DM)) u_dly_m (
    .clk_i, .rst_ni, .d_i({neg_q, m_q}), .q_o({neg_dly, m_dly})
  );

  erc_delay #(.W(2), .DEPTH(DC)) u_dly_flags (
    .clk_i, .rst_ni, .d_i({inside_rsq, cand_rsq}), .q_o({inside_dly, cand_dly})
  );

  logic [N2-1:0] r_div;
  logic [R_W-1:0] r_div_q;
  logic [R_W-1:0] r_div_r;

  always_ff @(posedge clk_i) begin
    r_div_q <= r_dly;
  end

  erc_div #(.N(N2), .D(H2)) u_div_radius (
    .clk_i,
    .num_i ({r_dly, {FRAC_BITS{1'b0}}}),
    .den_i (rs),
    .quot_o(radius)
  );

  // r rides along with the divider through a second delay
  erc_delay #(.W(R_W), .DEPTH(N2 - 1)) u_dly_r2 (
    .clk_i, .rst_ni, .d_i(r_div_q), .q_o(r_div_r)
  );
  assign r_div = N2'(r_div_r);

  // gap and raw contact vector
  logic [N2-1:0]             gap_raw_q;
  logic signed [2:0][N2:0]   vraw_q;
  logic [2:0]                neg_f_q;
  logic [2:0][M_W-1:0]       m_f_d;
  logic                      inside_f_q;
  logic                      cand_f_q;

  logic inside_rsq_hold;
  logic cand_hold;
  logic inside_f_d;
  logic cand_f_d;
  logic [2:0] neg_f_d;
  assign inside_rsq_hold = inside_dly;
  assign cand_hold       = cand_dly;

  erc_delay #(.W(3*M_W+5), .DEPTH(N2)) u_dly_m2 (
    .clk_i, .rst_ni,
    .d_i({inside_rsq_hold, cand_hold, neg_dly, m_dly}),
    .q_o({inside_f_d, cand_f_d, neg_f_d, m_f_d})
  );

  always_ff @(posedge clk_i) begin
    if (interior_q) begin
      gap_raw_q <= (radius > r_div) ? radius - r_div : '0;
    end else begin
      gap_raw_q <= (r_div > radius) ? r_div - radius : '0;
    end
    for (int a = 0; a < 3; a++) begin
      vraw_q[a] <= $signed({1'b0, N2'(m_f_d[a])}) - $signed({1'b0, pdiv[a]});
    end
    neg_f_q    <= neg_f_d;
    inside_f_q <= inside_f_d;
    cand_f_q   <= cand_f_d;
  end

  // saturate and gate the result word
  logic                          contact;
  logic signed [2:0][N2:0]       vsgn;
  logic signed [2:0][COORD_W-1:0] push;

  always_comb begin
    contact = cand_f_q && (gap_raw_q < N2'(cutoff_q));
    for (int a = 0; a < 3; a++) begin
      vsgn[a] = neg_f_q[a] ? -vraw_q[a] : vraw_q[a];
      if (!contact) begin
        push[a] = '0;
      end else if ($signed(vsgn[a]) > PUSH_MAX) begin
        push[a] = PUSH_MAX[COORD_W-1:0];
      end else if ($signed(vsgn[a]) < PUSH_MIN) begin
        push[a] = PUSH_MIN[COORD_W-1:0];
      end else begin
        push[a] = vsgn[a][COORD_W-1:0];
      end
    end
  end

  erc_out_t result_q;

  always_ff @(posedge clk_i) begin
    result_q.is_inside   <= inside_f_q;
    result_q.has_contact <= contact;
    result_q.gap         <= !contact ? '0 :
                            (gap_raw_q > GAP_MAX) ? GAP_MAX[COORD_W-2:0] :
                            gap_raw_q[COORD_W-2:0];
    result_q.push_x      <= push[0];
    result_q.push_y      <= push[1];
    result_q.push_z      <= push[2];
  end

  assign result_o = result_q;

endmodule

// ===== hdl/erc_delay.sv =====
// fixed-depth delay line for sideband data
module erc_delay #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] tap_q [DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DEPTH; k++) begin
        tap_q[k] <= '0;
      end
    end else begin
      tap_q[0] <= d_i;
      for (int k = 1; k < DEPTH; k++) begin
        tap_q[k] <= tap_q[k-1];
      end
    end
  end

  assign q_o = tap_q[DEPTH-1];

endmodule

// ===== hdl/erc_div.sv =====
// pipelined restoring divider, one quotient bit per stage
module erc_div #(
  parameter int N = 8,
  parameter int D = 8
) (
  input  logic         clk_i,
  input  logic [N-1:0] num_i,
  input  logic [D-1:0] den_i,
  output logic [N-1:0] quot_o
);

  logic [D-1:0] rem_q [N-1];
  logic [D-1:0] den_q [N-1];
  logic [N-1:0] w_q   [N];

  for (genvar g = 0; g < N; g++) begin : g_stage
    logic [D-1:0] rem_in;
    logic [D-1:0] den_in;
    logic [N-1:0] w_in;
    logic [D:0]   t;
    logic [D:0]   rem_n;
    logic         ge;

    if (g == 0) begin : g_first
      assign rem_in = '0;
      assign den_in = den_i;
      assign w_in   = num_i;
    end else begin : g_next
      assign rem_in = rem_q[g-1];
      assign den_in = den_q[g-1];
      assign w_in   = w_q[g-1];
    end

    always_comb begin
      t     = {rem_in, w_in[N-1]};
      ge    = t >= {1'b0, den_in};
      rem_n = ge ? t - {1'b0, den_in} : t;
    end

    // dividend bits shift out the top while quotient bits fill the bottom
    always_ff @(posedge clk_i) begin
      w_q[g] <= {w_in[N-2:0], ge};
    end

    if (g < N - 1) begin : g_keep
      always_ff @(posedge clk_i) begin
        rem_q[g] <= rem_n[D-1:0];
        den_q[g] <= den_in;
      end
    end
  end

  assign quot_o = w_q[N-1];

endmodule

// ===== hdl/erc_sqrt.sv =====
// pipelined floor square root, one root bit per stage
module erc_sqrt #(
  parameter int N = 8
) (
  input  logic             clk_i,
  input  logic [N-1:0]     rad_i,
  output logic [N/2-1:0]   root_o
);

  localparam int H = N / 2;

  logic [N-1:0] x_q    [H-1];
  logic [H+1:0] rem_q  [H-1];
  logic [H-1:0] root_q [H];

  for (genvar g = 0; g < H; g++) begin : g_stage
    logic [N-1:0] x_in;
    logic [H+1:0] rem_in;
    logic [H-1:0] root_in;
    logic [H+1:0] t;
    logic [H+1:0] trial;
    logic [H+1:0] rem_n;
    logic         ge;

    if (g == 0) begin : g_first
      assign x_in    = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign x_in    = x_q[g-1];
      assign rem_in  = rem_q[g-1];
      assign root_in = root_q[g-1];
    end

    always_comb begin
      t     = {rem_in[H-1:0], x_in[N-1:N-2]};
      trial = {root_in, 2'b01};
      ge    = t >= trial;
      rem_n = ge ? t - trial : t;
    end

    always_ff @(posedge clk_i) begin
      root_q[g] <= {root_in[H-2:0], ge};
    end

    if (g < H - 1) begin : g_keep
      always_ff @(posedge clk_i) begin
        x_q[g]   <= {x_in[N-3:0], 2'b00};
        rem_q[g] <= rem_n;
      end
    end
  end

  assign root_o = root_q[H-1];

endmodule

// ===== test/ellipsoid_region_contact_tb.sv =====
// testbench for the ellipsoid region contact pipeline: fixed-point predictor and scoreboard
module ellipsoid_region_contact_tb
  import erc_pkg::*;
();

  localparam int      FRAC      = 16;
  localparam int      DRAIN_CYC = 160;
  localparam int      WD_LIMIT  = 4000;
  localparam longint  S_MAX     = 64'sh7FFF_FFFF;
  localparam longint  S_MIN     = -64'sh8000_0000;
  localparam bit [63:0] Q_CAP   = 64'hFFFF_FFFF;
  localparam bit [63:0] ONE     = 64'd1 << FRAC;

  function automatic bit [63:0] isqrt128(bit [127:0] v);
    bit [63:0] y;
    bit [63:0] c;
    y = '0;
    for (int b = 63; b >= 0; b--) begin
      c = y | (64'd1 << b);
      if (({64'd0, c} * {64'd0, c}) <= v) y = c;
    end
    return y;
  endfunction

  class contact_scoreboard;
    logic signed [31:0] cen[3];
    bit [30:0]          semi[3];
    bit [30:0]          cutoff;
    bit                 interior;
    erc_out_t           pending[$];
    int                 errors;

    function new();
      cen = '{0, 0, 0};
      semi = '{31'd65536, 31'd65536, 31'd65536};
      cutoff = 0;
      interior = 1;
      errors = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [31:0] val);
      case (idx)
        CFG_CENTRE_X: cen[0] = val;
        CFG_CENTRE_Y: cen[1] = val;
        CFG_CENTRE_Z: cen[2] = val;
        CFG_SEMI_A:   semi[0] = val[30:0];
        CFG_SEMI_B:   semi[1] = val[30:0];
        CFG_SEMI_C:   semi[2] = val[30:0];
        CFG_CUTOFF:   cutoff = val[30:0];
        CFG_INTERIOR: interior = val[0];
        default: ;
      endcase
    endfunction

    function longint push_of(longint d, bit [63:0] m, bit [63:0] rs);
      bit [63:0] p;
      longint    v;
      p = (m << FRAC) / rs;
      v = longint'(m) - longint'(p);
      if (d < 0) v = -v;
      if (v > S_MAX) v = S_MAX;
      if (v < S_MIN) v = S_MIN;
      return v;
    endfunction

    function void note_word(erc_in_t w);
      longint     d[3];
      bit [63:0]  m[3];
      bit [127:0] sumsq;
      bit [127:0] qq;
      bit [63:0]  rsq, q, s, r, rs, radius, gap;
      bit         cand;
      erc_out_t   e;
      d[0] = longint'(w.pos_x) - longint'(cen[0]);
      d[1] = longint'(w.pos_y) - longint'(cen[1]);
      d[2] = longint'(w.pos_z) - longint'(cen[2]);
      sumsq = '0;
      rsq = '0;
      for (int i = 0; i < 3; i++) begin
        m[i] = d[i] < 0 ? 64'(-d[i]) : 64'(d[i]);
        sumsq += {64'd0, m[i]} * {64'd0, m[i]};
        s = semi[i] == 0 ? 64'd1 : 64'(semi[i]);
        q = (m[i] << FRAC) / s;
        if (q > Q_CAP) q = Q_CAP;
        qq = {64'd0, q} * {64'd0, q};
        rsq += qq[63:0] >> FRAC;
      end
      e = '0;
      e.is_inside = rsq <= ONE;
      cand = interior ? (rsq != 0 && rsq <= ONE) : (rsq >= ONE);
      if (cand) begin
        r = isqrt128(sumsq);
        rs = isqrt128({64'd0, rsq} << FRAC);
        if (rs != 0) begin
          radius = (r << FRAC) / rs;
          if (interior) gap = radius > r ? radius - r : 0;
          else gap = r > radius ? r - radius : 0;
          if (gap < 64'(cutoff)) begin
            e.has_contact = 1'b1;
            e.gap = gap > 64'h7FFF_FFFF ? 31'h7FFF_FFFF : gap[30:0];
            e.push_x = push_of(d[0], m[0], rs);
            e.push_y = push_of(d[1], m[1], rs);
            e.push_z = push_of(d[2], m[2], rs);
          end
        end
      end
      pending.push_back(e);
    endfunction

    function void check_word(erc_out_t a);
      erc_out_t e;
      if (pending.size() == 0) begin
        $display("%0t unexpected result word %h", $time, a);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.is_inside !== e.is_inside) begin
        $display("%0t is_inside exp %0d got %0d", $time, e.is_inside, a.is_inside);
        errors++;
      end
      if (a.has_contact !== e.has_contact) begin
        $display("%0t has_contact exp %0d got %0d", $time, e.has_contact, a.has_contact);
        errors++;
      end
      if (a.gap !== e.gap) begin
        $display("%0t gap exp %h got %h", $time, e.gap, a.gap);
        errors++;
      end
      if (a.push_x !== e.push_x) begin
        $display("%0t push_x exp %h got %h", $time, e.push_x, a.push_x);
        errors++;
      end
      if (a.push_y !== e.push_y) begin
        $display("%0t push_y exp %h got %h", $time, e.push_y, a.push_y);
        errors++;
      end
      if (a.push_z !== e.push_z) begin
        $display("%0t push_z exp %h got %h", $time, e.push_z, a.push_z);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  erc_in_t     in_i = '0;
  logic        done_o;
  erc_out_t    result_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;

  contact_scoreboard sb = new();
  int idle_cycles = 0;
  int burst_left = 0;

  ellipsoid_region_contact u_top (.*);

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_word(result_o);
    if ((start_i && !busy_o) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (rst_ni);
    while (idle_cycles < WD_LIMIT) @(posedge clk_i);
    $display("FAIL");
    $finish;
  end

  task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    sb.write_reg(idx, val);
    @(posedge clk_i);
  endtask

  task automatic send_word(erc_in_t w, bit bursty);
    int gap_cyc;
    if (bursty && burst_left == 0) begin
      gap_cyc = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
      if (gap_cyc > 0) begin
        start_i <= 1'b0;
        repeat (gap_cyc) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    if (burst_left > 0) burst_left--;
    start_i <= 1'b1;
    in_i <= w;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sb.note_word(w);
  endtask

  task automatic wait_results(bit settle);
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    if (settle) repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  task automatic send_xyz(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    erc_in_t w;
    w.pos_x = x;
    w.pos_y = y;
    w.pos_z = z;
    send_word(w, 1'b0);
  endtask

  // offset from the centre always within twice the semi-axis, so rsq lands near one
  function automatic logic [31:0] near_axis(logic [31:0] c, bit [30:0] s);
    longint span;
    longint off;
    span = 2 * longint'(s == 0 ? 31'd1 : s);
    off = longint'($urandom_range(0, 32'hFFFF_FFFF)) % (2 * span + 1) - span;
    if ($urandom_range(0, 3) == 0) off = off >>> $urandom_range(0, 8);
    return 32'(longint'($signed(c)) + off);
  endfunction

  initial begin
    erc_in_t w;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: zero cutoff never gives a contact
    send_xyz(0, 0, 0);
    send_xyz(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_xyz(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_xyz(32'h0001_0000, 0, 0);
    wait_results(1'b1);

    write_reg(CFG_CUTOFF, 32'h7FFF_FFFF);
    send_xyz(0, 0, 0);                     // at the centre
    send_xyz(1, 0, 0);                     // too near the centre to resolve
    send_xyz(32'h0000_8000, 0, 0);
    send_xyz(32'h0001_0000, 0, 0);         // on the surface
    send_xyz(32'hFFFF_4CCD, 32'hFFFF_4CCD, 0);
    send_xyz(32'h0000_93CD, 32'h0000_93CD, 32'h0000_93CD);
    send_xyz(32'h0002_0000, 0, 0);
    wait_results(1'b1);

    write_reg(CFG_INTERIOR, 0);
    write_reg(CFG_SEMI_A, 0);              // zero semi-axis acts as one lsb
    write_reg(CFG_SEMI_B, 32'hFFFF_FFFF);
    write_reg(CFG_SEMI_C, 32'h0000_0001);
    write_reg(CFG_CENTRE_X, 32'h8000_0000);
    write_reg(CFG_CENTRE_Y, 32'h7FFF_FFFF);
    write_reg(CFG_CENTRE_Z, 32'h8000_0000);
    send_xyz(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_xyz(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_xyz(32'h8000_0001, 32'h7FFF_FFFF, 32'h8000_0000);
    send_xyz(0, 0, 0);
    send_xyz(32'h8000_0000, 0, 32'h8000_0002);
    wait_results(1'b1);

    for (int ph = 0; ph < 8; ph++) begin
      for (int i = 0; i < 3; i++) begin
        write_reg(cfg_idx_e'(CFG_CENTRE_X + i),
                  ph == 7 ? 32'h7FFF_FFFF : ($urandom_range(0, 1) ? $urandom :
                  32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000)));
        write_reg(cfg_idx_e'(CFG_SEMI_A + i),
                  ph == 6 ? 32'h7FFF_FFFF :
                  ($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 32'h0010_0000)));
      end
      write_reg(CFG_CUTOFF, ph == 5 ? 0 :
                ($urandom_range(0, 2) == 0 ? $urandom : $urandom_range(1, 32'h0004_0000)));
      write_reg(CFG_INTERIOR, ph[0] ? $urandom : 32'(ph[1]));
      for (int n = 0; n < 160; n++) begin
        if (ph == 3 && n == 80) wait_results(1'b0);
        if ($urandom_range(0, 4) == 0) begin
          w.pos_x = $urandom;
          w.pos_y = $urandom;
          w.pos_z = $urandom;
        end else begin
          w.pos_x = near_axis(sb.cen[0], sb.semi[0]);
          w.pos_y = near_axis(sb.cen[1], sb.semi[1]);
          w.pos_z = near_axis(sb.cen[2], sb.semi[2]);
        end
        send_word(w, 1'b1);
      end
      wait_results(1'b1);
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/erc_pkg.sv
hdl/erc_delay.sv
hdl/erc_div.sv
hdl/erc_sqrt.sv
hdl/ellipsoid_region_contact.sv
test/ellipsoid_region_contact_tb.sv
